// ----- hw/rtl/sra_pkg.sv -----
package sra_pkg;

  localparam int AddrW       = 24;
  localparam int LenW        = 25;
  localparam int MemW        = 25;
  localparam int CntW        = 5;
  localparam int SrvW        = 4;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 25;
  localparam int MaxServers  = 16;
  localparam int ResultLimit = 16;
  localparam int ServerLimit = (MaxServers < ResultLimit) ? MaxServers : ResultLimit;
  localparam int DivW        = 25;
  localparam int DivCntW     = $clog2(DivW);

  localparam logic [MemW-1:0] MemSizeReset    = MemW'(1024);
  localparam logic [CntW-1:0] ServerCntReset  = CntW'(1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MEM_SIZE     = 2'd0,
    CFG_SERVER_COUNT = 2'd1
  } cfg_reg_e;

  // classified request handed from front to back
  typedef struct packed {
    logic            kind;
    logic            start_oor;
    logic [SrvW-1:0] srv;
    logic [AddrW-1:0] off;
    logic [LenW-1:0] len;
  } entry_t;

  typedef struct packed {
    logic [MemW-1:0] seg;
    logic [CntW-1:0] count;
  } seg_cfg_t;

  typedef struct packed {
    logic             op_kind;
    logic [SrvW-1:0]  server_index;
    logic [AddrW-1:0] local_offset;
    logic [LenW-1:0]  chunk_length;
    logic             last;
    logic             out_of_range;
  } chunk_t;

  // zero is taken as one, anything above the server limit as the limit
  function automatic logic [CntW-1:0] eff_count(input logic [CntW-1:0] sc);
    logic [CntW-1:0] res;
    res = sc;
    if (sc == '0) res = CntW'(1);
    else if (sc > CntW'(ServerLimit)) res = CntW'(ServerLimit);
    return res;
  endfunction

endpackage

// ----- hw/rtl/sra_if.sv -----
interface sra_cfg_if import sra_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

interface sra_req_if import sra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [AddrW-1:0] position;
  logic [LenW-1:0]  length;

  modport source (output valid, kind, position, length, input ready);
  modport sink   (input valid, kind, position, length, output ready);
endinterface

interface sra_chunk_if import sra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op_kind;
  logic [SrvW-1:0]  server_index;
  logic [AddrW-1:0] local_offset;
  logic [LenW-1:0]  chunk_length;
  logic             last;
  logic             out_of_range;

  modport source (output valid, op_kind, server_index, local_offset, chunk_length, last,
                  out_of_range, input ready);
  modport sink   (input valid, op_kind, server_index, local_offset, chunk_length, last,
                  out_of_range, output ready);
endinterface

// ----- hw/rtl/sra_div.sv -----
module sra_div import sra_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DivW-1:0] dividend_i,
  input  logic [DivW-1:0] divisor_i,
  output logic            done_o,
  output logic [DivW-1:0] quot_o,
  output logic [DivW-1:0] rem_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivW-1:0]    acc_q, acc_d;
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DivW-1:0]    dvs_q, dvs_d;
  logic [DivW:0]      trial;
  logic [DivW:0]      diff;
  logic               ge;

  // restoring division, one quotient bit a cycle
  assign trial = {acc_q, quo_q[DivW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      acc_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      acc_d = ge ? diff[DivW-1:0] : trial[DivW-1:0];
      quo_d = {quo_q[DivW-2:0], ge};
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == DivCntW'(DivW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = acc_q;

endmodule

// ----- hw/rtl/sra_queue.sv -----
module sra_queue import sra_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t data_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  logic       do_push, do_pop;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) fill_d = fill_q + 2'd1;
    else if (do_pop && !do_push) fill_d = fill_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// ----- hw/rtl/sra_front.sv -----
module sra_front import sra_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  sra_cfg_if.sink   cfg,
  sra_req_if.sink   req,
  output logic      push_o,
  output entry_t    push_data_o,
  input  logic      full_i,
  output seg_cfg_t  seg_cfg_o
);

  typedef enum logic [4:0] {
    F_IDLE = 5'b00001,
    F_CFG  = 5'b00010,
    F_SEG  = 5'b00100,
    F_DIV  = 5'b01000,
    F_PUSH = 5'b10000
  } front_state_e;

  front_state_e    state_q, state_d;
  logic [MemW-1:0] mem_size_q, mem_size_d;
  logic [CntW-1:0] srv_cnt_q, srv_cnt_d;
  logic [MemW-1:0] seg_q, seg_d;
  entry_t          pend_q, pend_d;
  logic [CntW-1:0] cnt_eff;
  logic            cfg_we;
  logic            div_start;
  logic            div_done;
  logic [DivW-1:0] div_dividend, div_divisor, div_quot, div_rem;

  assign cnt_eff   = eff_count(srv_cnt_q);
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;
  assign req.ready = state_q == F_IDLE;

  assign div_dividend = (state_q == F_CFG) ? DivW'(mem_size_q) : DivW'(req.position);
  assign div_divisor  = (state_q == F_CFG) ? DivW'(cnt_eff) : DivW'(seg_q);
  assign div_start    = (state_q == F_CFG) ||
                        ((state_q == F_IDLE) && req.valid && (seg_q != '0));

  sra_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    mem_size_d = mem_size_q;
    srv_cnt_d  = srv_cnt_q;
    if (cfg_we && (cfg.index == CFG_MEM_SIZE)) mem_size_d = cfg.data[MemW-1:0];
    if (cfg_we && (cfg.index == CFG_SERVER_COUNT)) srv_cnt_d = cfg.data[CntW-1:0];
  end

  always_comb begin
    state_d = state_q;
    seg_d   = seg_q;
    pend_d  = pend_q;
    push_o  = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (req.valid) begin
          pend_d.kind = req.kind;
          pend_d.len  = req.length;
          if (seg_q == '0) begin
            pend_d.start_oor = 1'b1;
            pend_d.srv       = '0;
            pend_d.off       = '0;
            state_d          = F_PUSH;
          end else begin
            state_d = F_DIV;
          end
        end
      end
      F_CFG: begin
        state_d = F_SEG;
      end
      F_SEG: begin
        if (div_done) begin
          seg_d   = div_quot[MemW-1:0];
          state_d = F_IDLE;
        end
      end
      F_DIV: begin
        if (div_done) begin
          pend_d.start_oor = div_quot >= DivW'(cnt_eff);
          pend_d.srv       = div_quot[SrvW-1:0];
          pend_d.off       = div_rem[AddrW-1:0];
          state_d          = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
    // a register write always recomputes the segment size
    if (cfg_we) state_d = F_CFG;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      mem_size_q <= MemSizeReset;
      srv_cnt_q  <= ServerCntReset;
      seg_q      <= MemSizeReset;
    end else begin
      state_q    <= state_d;
      mem_size_q <= mem_size_d;
      srv_cnt_q  <= srv_cnt_d;
      seg_q      <= seg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
  end

  assign push_data_o     = pend_q;
  assign seg_cfg_o.seg   = seg_q;
  assign seg_cfg_o.count = cnt_eff;

endmodule

// ----- hw/rtl/sra_back.sv -----
module sra_back import sra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  entry_t     q_data_i,
  output logic       pop_o,
  input  seg_cfg_t   seg_cfg_i,
  sra_chunk_if.source chunk
);

  logic            cur_valid_q, cur_valid_d;
  entry_t          cur_q, cur_d;
  logic            out_valid_q, out_valid_d;
  chunk_t          out_q, out_d;
  logic            adv;
  logic [LenW-1:0] room;
  logic            fits;
  logic            at_end;
  chunk_t          nxt;

  assign room   = LenW'(seg_cfg_i.seg) - LenW'(cur_q.off);
  assign fits   = room >= cur_q.len;
  assign at_end = (CntW'(cur_q.srv) + CntW'(1)) >= seg_cfg_i.count;
  assign adv    = cur_valid_q && (!out_valid_q || chunk.ready);

  always_comb begin
    nxt.op_kind      = cur_q.kind;
    nxt.server_index = cur_q.srv;
    nxt.local_offset = cur_q.off;
    nxt.chunk_length = room;
    nxt.last         = 1'b0;
    nxt.out_of_range = 1'b0;
    if (cur_q.start_oor) begin
      nxt.server_index = '0;
      nxt.local_offset = '0;
      nxt.chunk_length = cur_q.len;
      nxt.last         = 1'b1;
      nxt.out_of_range = 1'b1;
    end else if (fits) begin
      nxt.chunk_length = cur_q.len;
      nxt.last         = 1'b1;
    end else if (at_end) begin
      nxt.last         = 1'b1;
      nxt.out_of_range = 1'b1;
    end
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = q_valid_i && (!cur_valid_q || (adv && nxt.last));
    if (chunk.ready) out_valid_d = 1'b0;
    if (adv) begin
      out_valid_d = 1'b1;
      out_d       = nxt;
      if (nxt.last) begin
        cur_valid_d = 1'b0;
      end else begin
        cur_d.len = cur_q.len - room;
        cur_d.srv = cur_q.srv + SrvW'(1);
        cur_d.off = '0;
      end
    end
    if (pop_o) begin
      cur_valid_d = 1'b1;
      cur_d       = q_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign chunk.valid        = out_valid_q;
  assign chunk.op_kind      = out_q.op_kind;
  assign chunk.server_index = out_q.server_index;
  assign chunk.local_offset = out_q.local_offset;
  assign chunk.chunk_length = out_q.chunk_length;
  assign chunk.last         = out_q.last;
  assign chunk.out_of_range = out_q.out_of_range;

  // an out-of-range chunk always ends its request
  a_oor_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.out_of_range |-> out_q.last)
    else $error("out-of-range chunk without last");

  // a chunk that does not end the request fills the rest of its segment, so it is never empty
  a_mid_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.last |-> out_q.chunk_length != '0)
    else $error("empty chunk in the middle of a request");

  // in-range chunks address an existing server
  a_srv_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.out_of_range |->
      CntW'(out_q.server_index) < seg_cfg_i.count)
    else $error("server index beyond the server count");

  // a new request is only loaded once the previous one has finished
  a_pop_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !cur_valid_q || (adv && nxt.last))
    else $error("request loaded over one still in progress");

endmodule

// ----- hw/rtl/striped_range_splitter_top.sv -----
// striped range splitter: a shared memory of mem_size bytes is split into
// server_count equal segments of floor(mem_size / server_count) bytes, and
// each read or write request (kind, position, length) comes out as one chunk
// transfer per segment it touches, in address order, each giving the server,
// the offset inside that server's segment, the chunk length and a last flag.
// a zero length gives one empty chunk. a request starting beyond the end of the
// last whole segment gives a single chunk with out_of_range set; one running
// past the end is cut at the end of the last segment, flagged and ended there.
// the front end takes one request at a time: it accepts it, runs the shared
// bit-serial divider to find the start segment and its offset, collects the
// quotient and hands the request to a two-entry queue; with a zero segment
// size it skips the divider. the back end gives one chunk per cycle from that
// queue while the receiver is ready, so chunk output of one request overlaps
// the division of the next. a register write restarts the segment-size
// division, and requests are held off until it finishes. writes are only to
// be made while no request is in flight; the write channel is always ready
module striped_range_splitter_top import sra_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sra_cfg_if.sink       cfg_i,
  sra_req_if.sink       req_i,
  sra_chunk_if.source   chunk_o
);

  // front to back hand-off
  logic     push;
  entry_t   push_data;
  logic     q_full;
  logic     q_valid;
  logic     pop;
  entry_t   q_data;
  seg_cfg_t seg_cfg;

  // register file, segment size division and start-segment division
  sra_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg         (cfg_i),
    .req         (req_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (q_full),
    .seg_cfg_o   (seg_cfg)
  );

  // short queue so the divider and the chunk walker stall independently
  sra_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .data_o      (q_data)
  );

  // walks segments one chunk per cycle, while the receiver is ready, into a registered output stage
  sra_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .pop_o     (pop),
    .seg_cfg_i (seg_cfg),
    .chunk     (chunk_o)
  );

endmodule

// ----- test/tb_striped_range_splitter_top.sv -----
module tb_striped_range_splitter_top;
  import sra_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 5000;
  localparam int Phases        = 7;
  localparam int ItemsPerPhase = 22;
  localparam int SettleCycles  = 64;
  localparam logic [LenW-1:0] FullSpan = LenW'(25'h1000000);

  // directed stimulus rows: either a register write or a request
  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           what;
    cfg_reg_e            reg_idx;
    logic [CfgDataW-1:0] wdata;
    logic                kind;
    logic [AddrW-1:0]    pos;
    logic [LenW-1:0]     len;
    bit                  typed;
    chunk_t              want;
  } row_t;

  logic clk;
  logic rst_n;

  sra_cfg_if   cfg_bus();
  sra_req_if   req_bus();
  sra_chunk_if chunk_bus();

  striped_range_splitter_top uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cfg_i   (cfg_bus),
    .req_i   (req_bus),
    .chunk_o (chunk_bus)
  );

  // mirror of the register file as last written
  logic [MemW-1:0] mem_bytes;
  logic [CntW-1:0] servers_set;

  chunk_t pending_chunks[$];
  int     errors;
  int     idle_cycles;
  bit     src_gaps;
  bit     sink_stalls;
  bit     hold_off_req;

  // typed results only where they follow at a glance; the rest go to the predictor
  row_t directed [27] = '{
    // reset settings: one segment of 1024 bytes
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd0, 25'd0, 1'b1,
      '{1'b0, 4'd0, 24'd0, 25'd0, 1'b1, 1'b0}},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd0, 25'd1024, 1'b1,
      '{1'b1, 4'd0, 24'd0, 25'd1024, 1'b1, 1'b0}},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd1023, 25'd1, 1'b1,
      '{1'b0, 4'd0, 24'd1023, 25'd1, 1'b1, 1'b0}},
    // start beyond the memory
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd1024, 25'd5, 1'b1,
      '{1'b1, 4'd0, 24'd0, 25'd5, 1'b1, 1'b1}},
    // runs past the end of the last segment
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd1000, 25'd100, 1'b1,
      '{1'b0, 4'd0, 24'd1000, 25'd24, 1'b1, 1'b1}},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'hFFFFFF, 25'h1000000, 1'b1,
      '{1'b1, 4'd0, 24'd0, 25'h1000000, 1'b1, 1'b1}},
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd4, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd100, 25'd700, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd1000, 25'd100, 1'b0, '0},
    // largest memory over the most servers, full sweep
    '{ROW_CFG, CFG_MEM_SIZE, 25'h1000000, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd16, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd0, 25'h1000000, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'hFFFFFF, 25'd1, 1'b0, '0},
    // zero server count taken as one
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd0, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'hFFFFFF, 25'h1000000, 1'b0, '0},
    // count above the limit clamped
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd31, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd5, 25'h0ABCDE, 1'b0, '0},
    // smallest memory
    '{ROW_CFG, CFG_MEM_SIZE, 25'd1, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd1, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd0, 25'd1, 1'b1,
      '{1'b0, 4'd0, 24'd0, 25'd1, 1'b1, 1'b0}},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd1, 25'd0, 1'b1,
      '{1'b1, 4'd0, 24'd0, 25'd0, 1'b1, 1'b1}},
    // segment size zero: nothing is in range
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd16, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd0, 25'd0, 1'b1,
      '{1'b1, 4'd0, 24'd0, 25'd0, 1'b1, 1'b1}},
    // uneven split leaves a tail byte outside every segment
    '{ROW_CFG, CFG_MEM_SIZE, 25'd1000, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_SERVER_COUNT, 25'd3, 1'b0, '0, '0, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b0, 24'd998, 25'd2, 1'b0, '0},
    '{ROW_REQ, CFG_MEM_SIZE, '0, 1'b1, 24'd999, 25'd0, 1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // effective server count: zero as one, above the limit as the limit
  function automatic int unsigned servers_used();
    int unsigned c;
    c = servers_set;
    if (c == 0) c = 1;
    else if (c > ServerLimit) c = ServerLimit;
    return c;
  endfunction

  function automatic int unsigned segment_bytes();
    return mem_bytes / servers_used();
  endfunction

  function automatic void queue_chunk(input logic k, input int unsigned srv,
                                      input int unsigned off, input int unsigned len,
                                      input logic last, input logic oor);
    chunk_t c;
    c.op_kind      = k;
    c.server_index = SrvW'(srv);
    c.local_offset = AddrW'(off);
    c.chunk_length = LenW'(len);
    c.last         = last;
    c.out_of_range = oor;
    pending_chunks.push_back(c);
  endfunction

  // walk the request segment by segment, one chunk per segment touched
  function automatic void split_request(input logic k, input logic [AddrW-1:0] p,
                                        input logic [LenW-1:0] l);
    int unsigned cnt, seg, pos, len, x, off, room;
    cnt = servers_used();
    seg = segment_bytes();
    pos = p;
    len = l;
    for (int n = 0; n < ResultLimit; n++) begin
      if (seg == 0 || pos / seg >= cnt) begin
        queue_chunk(k, 0, 0, len, 1'b1, 1'b1);
        return;
      end
      x    = pos / seg;
      off  = pos - x * seg;
      room = seg - off;
      if (room >= len) begin
        queue_chunk(k, x, off, len, 1'b1, 1'b0);
        return;
      end
      if (x + 1 >= cnt) begin
        queue_chunk(k, x, off, room, 1'b1, 1'b1);
        return;
      end
      queue_chunk(k, x, off, room, 1'b0, 1'b0);
      pos += room;
      len -= room;
    end
  endfunction

  // register writes wait until every chunk in flight has come out
  task automatic write_register(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    while (pending_chunks.size() != 0) @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.index = idx;
    cfg_bus.data  = data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_MEM_SIZE:     mem_bytes   = data[MemW-1:0];
      CFG_SERVER_COUNT: servers_set = data[CntW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  // one request transfer; results either typed in or predicted at acceptance
  task automatic send_request(input logic k, input logic [AddrW-1:0] p,
                              input logic [LenW-1:0] l, input bit typed, input chunk_t want);
    if (src_gaps && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 17)) @(negedge clk);
    req_bus.valid    = 1'b1;
    req_bus.kind     = k;
    req_bus.position = p;
    req_bus.length   = l;
    do @(posedge clk); while (!req_bus.ready);
    if (typed) pending_chunks.push_back(want);
    else split_request(k, p, l);
    @(negedge clk);
    req_bus.valid = 1'b0;
  endtask

  // four-state compare so unknown bits on the outputs show up
  function automatic void check_field(input string name, input logic [LenW-1:0] want,
                                      input logic [LenW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // chunk checker, sampled at the rising edge
  always @(posedge clk) begin
    chunk_t want;
    if (rst_n && chunk_bus.valid && chunk_bus.ready) begin
      if (pending_chunks.size() == 0) begin
        $error("chunk transfer with nothing pending: server %0d offset %0d length %0d",
               chunk_bus.server_index, chunk_bus.local_offset, chunk_bus.chunk_length);
        errors++;
      end else begin
        want = pending_chunks.pop_front();
        check_field("op_kind", LenW'(want.op_kind), LenW'(chunk_bus.op_kind));
        check_field("server_index", LenW'(want.server_index), LenW'(chunk_bus.server_index));
        check_field("local_offset", LenW'(want.local_offset), LenW'(chunk_bus.local_offset));
        check_field("chunk_length", want.chunk_length, chunk_bus.chunk_length);
        check_field("last", LenW'(want.last), LenW'(chunk_bus.last));
        check_field("out_of_range", LenW'(want.out_of_range), LenW'(chunk_bus.out_of_range));
      end
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cfg_bus.valid && cfg_bus.ready) || (req_bus.valid && req_bus.ready) ||
          (chunk_bus.valid && chunk_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // chunk receiver: random stall bursts, plus one long hold-off on request
  initial begin
    chunk_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req    = 1'b0;
        chunk_bus.ready = 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
      end
      if (sink_stalls && $urandom_range(0, 9) == 0) begin
        chunk_bus.ready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end
      chunk_bus.ready = 1'b1;
    end
  end

  // main sequence
  initial begin
    logic                kind;
    logic [AddrW-1:0]    pos;
    logic [LenW-1:0]     len;
    logic [CfgDataW-1:0] mem_pick;
    logic [CntW-1:0]     cnt_pick;
    int unsigned         seg, total;

    rst_n            = 1'b0;
    cfg_bus.valid    = 1'b0;
    cfg_bus.index    = CFG_MEM_SIZE;
    cfg_bus.data     = '0;
    req_bus.valid    = 1'b0;
    req_bus.kind     = 1'b0;
    req_bus.position = '0;
    req_bus.length   = '0;
    errors           = 0;
    idle_cycles      = 0;
    src_gaps         = 1'b1;
    sink_stalls      = 1'b1;
    hold_off_req     = 1'b0;
    mem_bytes        = MemSizeReset;
    servers_set      = ServerCntReset;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed[i]) begin
      if (directed[i].what == ROW_CFG)
        write_register(directed[i].reg_idx, directed[i].wdata);
      else
        send_request(directed[i].kind, directed[i].pos, directed[i].len,
                     directed[i].typed, directed[i].want);
    end

    for (int ph = 0; ph < Phases; ph++) begin
      // first two phases at the extremes, the rest random
      case (ph)
        0: begin
          mem_pick = FullSpan;
          cnt_pick = CntW'(16);
        end
        1: begin
          mem_pick = CfgDataW'($urandom_range(1, 64));
          cnt_pick = CntW'($urandom_range(17, 31));
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       mem_pick = CfgDataW'($urandom_range(1, 64));
            1:       mem_pick = CfgDataW'($urandom_range(65, 65535));
            2:       mem_pick = FullSpan;
            3:       mem_pick = CfgDataW'($urandom_range(1, 32'h1000000));
            default: mem_pick = CfgDataW'(1024);
          endcase
          if ($urandom_range(0, 4) == 0) cnt_pick = CntW'($urandom_range(0, 31));
          else cnt_pick = CntW'($urandom_range(1, 16));
        end
      endcase
      // quiet last phase: nobody idles
      if (ph == Phases - 1) begin
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
      end
      write_register(CFG_MEM_SIZE, mem_pick);
      // upper data bits are beyond the register and must be ignored
      write_register(CFG_SERVER_COUNT, {20'($urandom), cnt_pick});
      // long receiver hold-off while requests keep coming
      if (ph == 2) hold_off_req = 1'b1;

      seg   = segment_bytes();
      total = seg * servers_used();
      for (int i = 0; i < ItemsPerPhase; i++) begin
        kind = 1'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // well-formed: start in range, spanning a few segments
            pos = (total == 0) ? AddrW'($urandom) : AddrW'($urandom_range(0, total - 1));
            len = LenW'($urandom_range(0, (seg == 0) ? 16 :
                        ((3 * seg > 32'h1000000) ? 32'h1000000 : 3 * seg)));
          end
          6: begin
            pos = (total == 0) ? '0 : AddrW'($urandom_range(0, total - 1));
            len = LenW'($urandom_range(0, 1));
          end
          7: begin
            // close to the end of the last segment
            pos = (total == 0) ? '0 :
                  AddrW'(total - $urandom_range(1, (total < 8) ? total : 8));
            len = LenW'($urandom_range(0, seg + 4));
          end
          default: begin
            pos = AddrW'($urandom);
            len = ($urandom_range(0, 3) == 0) ? FullSpan :
                  LenW'($urandom_range(0, 32'h1000000));
          end
        endcase
        send_request(kind, pos, len, 1'b0, '0);
      end
    end

    while (pending_chunks.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
    if (errors == 0 && pending_chunks.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
